FILE: hw/rtl/cubic_bspline_point_generator_defines.svh
// ----------------------------------------------------------------------------
// Cubic B-spline point generator: assertion macros
// Shared property forms for the checker of the point generator.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_POINT_GENERATOR_DEFINES_SVH
`define CUBIC_BSPLINE_POINT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define CBS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbs check failed");

// next-cycle implication
`define CBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbs check failed");

`endif

FILE: hw/rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Types and constants shared by the B-spline point generator modules.
// ----------------------------------------------------------------------------
package cbs_pkg;

	localparam int COORD_W     = 16;
	localparam int PPS_W       = 4;
	localparam int U_W         = 17;
	localparam int FRAC_W      = 16;
	localparam int WGT_W       = 21;
	localparam int ACC_W       = 40;
	localparam int BLEND_SHIFT = 17;
	localparam int DIV_NUM_W   = 32;
	localparam int DIV_DEN_W   = 16;
	localparam int RCP_IN_W    = 18;
	localparam int RCP_W       = 20;
	localparam int RCP3_SHIFT  = 21;

	localparam logic [RCP_W-1:0]     RCP3      = 20'd699051;
	localparam logic [PPS_W-1:0]     PPS_RESET = 4'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic                     is_move;
		logic                     clamped;
		logic [PPS_W-1:0]         pps;
		logic [COORD_W-1:0]       span;
		logic [3:0][COORD_W-1:0]  px;
		logic [3:0][COORD_W-1:0]  py;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_UGO,
		B_UWAIT,
		B_POW2,
		B_POW3,
		B_WGT,
		B_MAC,
		B_XGO,
		B_YGO,
		B_OUT
	} bstate_t;

	function automatic coord_t sat_coord(input logic neg, input logic [DIV_NUM_W-1:0] q);
		coord_t r;
		if (neg) begin
			if (q > DIV_NUM_W'(32768)) r = coord_t'(16'h8000);
			else r = coord_t'(-q[COORD_W-1:0]);
		end else begin
			if (q > DIV_NUM_W'(32767)) r = coord_t'(16'h7fff);
			else r = coord_t'(q[COORD_W-1:0]);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/cbs_queue.sv
// ----------------------------------------------------------------------------
// cbs_queue
// Two-entry job queue between the front and the back part.
// ----------------------------------------------------------------------------
module cbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cbs_pkg::job_t  din,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output cbs_pkg::job_t  dout
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	cbs_pkg::job_t     mem_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop) rd_q <= rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

endmodule

FILE: hw/rtl/cbs_front.sv
// ----------------------------------------------------------------------------
// cbs_front
// Accepts control points, keeps the window and queues move-to and segment jobs.
// ----------------------------------------------------------------------------
module cbs_front #(
	parameter int MAX_STEPS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          point_x,
	input  logic signed [15:0]          point_y,
	input  logic                        first_point,
	input  logic [cbs_pkg::PPS_W-1:0]   pps,
	input  logic                        q_full,
	output logic                        push,
	output cbs_pkg::job_t               job
);

	localparam int LIM_W = 21;

	cbs_pkg::coord_t    wx_q [3];
	cbs_pkg::coord_t    wy_q [3];
	logic [1:0]         seen_q;
	logic [1:0]         seen;
	logic               acc;
	logic signed [16:0] dx, dy;
	logic [15:0]        ax, ay, span;
	logic [LIM_W-1:0]   lim;
	logic               clamped, has_pts;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign seen     = first_point ? 2'd0 : seen_q;

	always_comb begin
		dx = {wx_q[1][15], wx_q[1]} - {wx_q[2][15], wx_q[2]};
		dy = {wy_q[1][15], wy_q[1]} - {wy_q[2][15], wy_q[2]};
		ax = dx[16] ? 16'(-dx) : dx[15:0];
		ay = dy[16] ? 16'(-dy) : dy[15:0];
		span = (ax > ay) ? ax : ay;
		lim = LIM_W'(MAX_STEPS + 1) * LIM_W'(pps);
		clamped = (pps == '0) || (LIM_W'(span) >= lim);
		has_pts = (span != '0) && (clamped || (span >= 16'(pps)));
		push = acc && ((seen == 2'd2) || ((seen == 2'd3) && has_pts));
		job.is_move = (seen == 2'd2);
		job.clamped = clamped;
		job.pps     = pps;
		job.span    = span;
		job.px      = {point_x, wx_q[2], wx_q[1], wx_q[0]};
		job.py      = {point_y, wy_q[2], wy_q[1], wy_q[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				wx_q[i] <= '0;
				wy_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (acc) begin
			wx_q[0] <= wx_q[1];
			wx_q[1] <= wx_q[2];
			wx_q[2] <= point_x;
			wy_q[0] <= wy_q[1];
			wy_q[1] <= wy_q[2];
			wy_q[2] <= point_y;
			seen_q  <= (seen == 2'd3) ? 2'd3 : seen + 2'd1;
		end
	end

endmodule

FILE: hw/rtl/cbs_div.sv
// ----------------------------------------------------------------------------
// cbs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cbs_pkg::DIV_NUM_W-1:0]   num,
	input  logic [cbs_pkg::DIV_DEN_W-1:0]   den,
	output logic                            done,
	output logic [cbs_pkg::DIV_NUM_W-1:0]   quo
);

	localparam int NW = cbs_pkg::DIV_NUM_W;
	localparam int DW = cbs_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW);

	logic [NW-1:0] sh_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fit;

	assign trial = {rem_q, sh_q[NW-1]};
	assign fit   = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = sh_q;

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			sh_q  <= {sh_q[NW-2:0], fit};
			rem_q <= fit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/cbs_back.sv
// ----------------------------------------------------------------------------
// cbs_back
// Runs queued jobs: parameter step, basis weights, blend and output register.
// ----------------------------------------------------------------------------
module cbs_back #(
	parameter int MAX_STEPS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  cbs_pkg::job_t         job,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    out_x,
	output logic signed [15:0]    out_y,
	output logic                  pen_down,
	output logic                  last_of_run
);

	localparam int KW  = $clog2(MAX_STEPS + 1);
	localparam int UW  = cbs_pkg::U_W;
	localparam int WW  = cbs_pkg::WGT_W;
	localparam int AW  = cbs_pkg::ACC_W;
	localparam int NW  = cbs_pkg::DIV_NUM_W;
	localparam int DW  = cbs_pkg::DIV_DEN_W;
	localparam int FW  = cbs_pkg::FRAC_W;
	localparam int RW  = cbs_pkg::RCP_IN_W;
	localparam int RPW = cbs_pkg::RCP_IN_W + cbs_pkg::RCP_W;

	cbs_pkg::bstate_t         st_q, st_nx;
	cbs_pkg::job_t            job_q;
	logic [KW-1:0]            k_q;
	logic [UW-1:0]            kp_q;
	logic [UW-1:0]            u_q, u2_q, u3_q;
	logic signed [WW-1:0]     b_q [4];
	logic [2:0]               mi_q;
	logic signed [AW-1:0]     accx_q, accy_q;
	cbs_pkg::coord_t          qx_q, qy_q;
	logic                     ov_q, ol_q, op_q;
	cbs_pkg::coord_t          ox_q, oy_q;

	logic                     div_start, div_done;
	logic [NW-1:0]            div_num, div_quo;
	logic [DW-1:0]            div_den;
	logic [2*UW-1:0]          mul_u;
	logic signed [WW-1:0]     ue, u2e, u3e;
	logic signed [WW-1:0]     wsel;
	cbs_pkg::coord_t          psel;
	logic signed [AW-1:0]     prod, acc_sel, mag;
	logic [RW-1:0]            rin;
	logic [RPW-1:0]           rprod;
	logic [NW-1:0]            q3;
	logic                     last, out_free, load;

	assign out_free = !ov_q || out_ready;

	always_comb begin
		mul_u = (st_q == cbs_pkg::B_POW2) ? u_q * u_q : u2_q * u_q;
		ue  = WW'(u_q);
		u2e = WW'(u2_q);
		u3e = WW'(u3_q);
		wsel = b_q[mi_q[1:0]];
		psel = mi_q[2] ? cbs_pkg::coord_t'(job_q.py[mi_q[1:0]])
			: cbs_pkg::coord_t'(job_q.px[mi_q[1:0]]);
		prod = AW'(wsel) * AW'(psel);
		acc_sel = (st_q == cbs_pkg::B_YGO) ? accy_q : accx_q;
		mag = acc_sel[AW-1] ? -acc_sel : acc_sel;
		rin = job_q.is_move ? RW'(mag >> 1) : RW'(mag >> cbs_pkg::BLEND_SHIFT);
		rprod = RPW'(rin) * RPW'(cbs_pkg::RCP3);
		q3 = NW'(rprod >> cbs_pkg::RCP3_SHIFT);
		if (job_q.is_move) last = 1'b1;
		else if (job_q.clamped) last = (k_q == KW'(MAX_STEPS));
		else last = ((kp_q + UW'(job_q.pps)) > UW'(job_q.span));
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			cbs_pkg::B_IDLE:  if (!q_empty) st_nx = job.is_move ? cbs_pkg::B_XGO : cbs_pkg::B_UGO;
			cbs_pkg::B_UGO:   st_nx = cbs_pkg::B_UWAIT;
			cbs_pkg::B_UWAIT: if (div_done) st_nx = cbs_pkg::B_POW2;
			cbs_pkg::B_POW2:  st_nx = cbs_pkg::B_POW3;
			cbs_pkg::B_POW3:  st_nx = cbs_pkg::B_WGT;
			cbs_pkg::B_WGT:   st_nx = cbs_pkg::B_MAC;
			cbs_pkg::B_MAC:   if (mi_q == 3'd7) st_nx = cbs_pkg::B_XGO;
			cbs_pkg::B_XGO:   st_nx = cbs_pkg::B_YGO;
			cbs_pkg::B_YGO:   st_nx = cbs_pkg::B_OUT;
			cbs_pkg::B_OUT:   if (out_free) st_nx = last ? cbs_pkg::B_IDLE : cbs_pkg::B_UGO;
			default:          st_nx = cbs_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = DW'(1);
		load      = 1'b0;
		unique case (st_q)
			cbs_pkg::B_IDLE: pop = !q_empty;
			cbs_pkg::B_UGO: begin
				div_start = 1'b1;
				if (job_q.clamped) begin
					div_num = NW'({FW'(k_q), FW'(0)});
					div_den = DW'(MAX_STEPS);
				end else begin
					div_num = {kp_q[FW-1:0], FW'(0)};
					div_den = job_q.span;
				end
			end
			cbs_pkg::B_OUT: load = out_free;
			default: ;
		endcase
	end

	cbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		case (st_q)
			cbs_pkg::B_IDLE: begin
				job_q <= job;
				k_q   <= KW'(1);
				kp_q  <= UW'(job.pps);
				accx_q <= AW'(cbs_pkg::coord_t'(job.px[1]))
					+ (AW'(cbs_pkg::coord_t'(job.px[2])) <<< 2)
					+ AW'(cbs_pkg::coord_t'(job.px[3]));
				accy_q <= AW'(cbs_pkg::coord_t'(job.py[1]))
					+ (AW'(cbs_pkg::coord_t'(job.py[2])) <<< 2)
					+ AW'(cbs_pkg::coord_t'(job.py[3]));
			end
			cbs_pkg::B_UWAIT: if (div_done) u_q <= div_quo[UW-1:0];
			cbs_pkg::B_POW2: u2_q <= mul_u[FW+UW-1:FW];
			cbs_pkg::B_POW3: u3_q <= mul_u[FW+UW-1:FW];
			cbs_pkg::B_WGT: begin
				b_q[0] <= WW'(65536) - WW'(3) * ue + WW'(3) * u2e - u3e;
				b_q[1] <= WW'(3) * u3e - WW'(6) * u2e + WW'(262144);
				b_q[2] <= WW'(3) * u2e - WW'(3) * u3e + WW'(3) * ue + WW'(65536);
				b_q[3] <= u3e;
				accx_q <= '0;
				accy_q <= '0;
				mi_q   <= '0;
			end
			cbs_pkg::B_MAC: begin
				mi_q <= mi_q + 3'd1;
				if (mi_q[2]) accy_q <= accy_q + prod;
				else accx_q <= accx_q + prod;
			end
			cbs_pkg::B_XGO: qx_q <= cbs_pkg::sat_coord(accx_q[AW-1], q3);
			cbs_pkg::B_YGO: qy_q <= cbs_pkg::sat_coord(accy_q[AW-1], q3);
			cbs_pkg::B_OUT: if (load && !last) begin
				k_q  <= k_q + KW'(1);
				kp_q <= kp_q + UW'(job_q.pps);
			end
			default: ;
		endcase
		if (load) begin
			ox_q <= qx_q;
			oy_q <= qy_q;
			ol_q <= last;
			op_q <= !job_q.is_move;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cbs_pkg::B_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid   = ov_q;
	assign out_x       = ox_q;
	assign out_y       = oy_q;
	assign pen_down    = op_q;
	assign last_of_run = ol_q;

endmodule

FILE: hw/rtl/cubic_bspline_point_generator.sv
// ----------------------------------------------------------------------------
// cubic_bspline_point_generator
// Uniform cubic B-spline rasterizer fed one control point per item.
//
//   channel  signals                                    direction
//   input    in_valid/in_ready, point_x, point_y, first_point   in
//   output   out_valid/out_ready, out_x, out_y, pen_down, last_of_run  out
//   config   cfg_we, cfg_wdata (pixels_per_step)        in
//
// An input item is taken while the two-entry job queue has room.
// A move-to point skips the divide for u and the weight steps; each line-to point runs
// the 32-bit serial divide for u, then powers, weights and a serial blend.
// A window yields up to MAX_STEPS points.
// Reset clears the window, the point count and the step register to 3.
// A stalled output holds its item; the front keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module cubic_bspline_point_generator #(
	parameter int MAX_STEPS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic               first_point,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic               pen_down,
	output logic               last_of_run
);

	logic [cbs_pkg::PPS_W-1:0] pps_q;
	logic                      push, pop, q_full, q_empty;
	cbs_pkg::job_t             fjob, bjob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pps_q <= cbs_pkg::PPS_RESET;
		else if (cfg_we) pps_q <= cfg_wdata;
	end

	cbs_front #(.MAX_STEPS(MAX_STEPS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.first_point (first_point),
		.pps         (pps_q),
		.q_full      (q_full),
		.push        (push),
		.job         (fjob)
	);

	cbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (fjob),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.dout   (bjob)
	);

	cbs_back #(.MAX_STEPS(MAX_STEPS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.job         (bjob),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.pen_down    (pen_down),
		.last_of_run (last_of_run)
	);

endmodule

FILE: hw/rtl/cbs_checker.sv
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks on the result channel of the point generator.
// ----------------------------------------------------------------------------
`include "cubic_bspline_point_generator_defines.svh"

module cbs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic               pen_down,
	input logic               last_of_run
);

	`CBS_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(pen_down) && $stable(last_of_run))
	`CBS_ASSERT_IMP(a_move_last, out_valid && !pen_down, last_of_run)
	`CBS_ASSERT_NXT(a_run_draws, out_valid && out_ready && !last_of_run, !out_valid || pen_down)

endmodule

bind cubic_bspline_point_generator cbs_checker u_cbs_checker (.*);

FILE: tb/sv/tb_cubic_bspline_point_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cubic_bspline_point_generator
// Feeds control points into the B-spline point generator and checks every
// emitted curve point against a behavioral rasterizer kept in the bench,
// over several step settings, random idling on both sides and long stalls.
// ----------------------------------------------------------------------------
module tb_cubic_bspline_point_generator;

	localparam int MAX_STEPS   = 64;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 300;

	typedef struct {
		cbs_pkg::coord_t x;
		cbs_pkg::coord_t y;
		bit              pen;
		bit              last;
	} curve_point_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	cbs_pkg::coord_t point_x;
	cbs_pkg::coord_t point_y;
	logic            first_point;
	logic            cfg_we;
	logic [3:0]      cfg_wdata;
	logic            out_valid;
	logic            out_ready;
	cbs_pkg::coord_t out_x;
	cbs_pkg::coord_t out_y;
	logic            pen_down;
	logic            last_of_run;

	curve_point_t pending_points[$];
	int           win_x[3];
	int           win_y[3];
	int           points_held;
	int           step_pixels;
	int           errors;
	int           send_gap;
	int           recv_gap;
	int           hold_req;
	int           hold_left;
	int           quiet_cycles;

	cubic_bspline_point_generator #(.MAX_STEPS(MAX_STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .first_point(first_point),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .pen_down(pen_down), .last_of_run(last_of_run)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic cbs_pkg::coord_t blend_coord(longint b0, longint b1, longint b2,
			longint b3, int p0, int p1, int p2, int p3);
		longint s;
		longint q;
		s = b0 * p0 + b1 * p1 + b2 * p2 + b3 * p3;
		q = s / 393216;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return cbs_pkg::coord_t'(q);
	endfunction

	task automatic rasterize_point(input int px, input int py, input bit first);
		curve_point_t cp;
		int     sx, sy, span, n;
		bit     clamped;
		longint u, u2, u3, b0, b1, b2, b3;
		if (first) points_held = 0;
		if (points_held == 2) begin
			cp.x = cbs_pkg::coord_t'((win_x[1] + 4 * win_x[2] + px) / 6);
			cp.y = cbs_pkg::coord_t'((win_y[1] + 4 * win_y[2] + py) / 6);
			cp.pen = 1'b0;
			cp.last = 1'b1;
			pending_points.push_back(cp);
		end else if (points_held == 3) begin
			sx = win_x[1] > win_x[2] ? win_x[1] - win_x[2] : win_x[2] - win_x[1];
			sy = win_y[1] > win_y[2] ? win_y[1] - win_y[2] : win_y[2] - win_y[1];
			span = sx > sy ? sx : sy;
			n = 0;
			clamped = 1'b0;
			if (span != 0) begin
				if (step_pixels == 0) clamped = 1'b1;
				else begin
					n = span / step_pixels;
					if (n > MAX_STEPS) clamped = 1'b1;
				end
				if (clamped) n = MAX_STEPS;
			end
			for (int k = 1; k <= n; k++) begin
				if (clamped) u = (longint'(k) << 16) / MAX_STEPS;
				else u = ((longint'(k) * step_pixels) << 16) / span;
				u2 = (u * u) >>> 16;
				u3 = (u2 * u) >>> 16;
				b0 = 65536 - 3 * u + 3 * u2 - u3;
				b1 = 3 * u3 - 6 * u2 + 262144;
				b2 = -3 * u3 + 3 * u2 + 3 * u + 65536;
				b3 = u3;
				cp.x = blend_coord(b0, b1, b2, b3, win_x[0], win_x[1], win_x[2], px);
				cp.y = blend_coord(b0, b1, b2, b3, win_y[0], win_y[1], win_y[2], py);
				cp.pen = 1'b1;
				cp.last = (k == n);
				pending_points.push_back(cp);
			end
		end
		win_x[0] = win_x[1];
		win_x[1] = win_x[2];
		win_x[2] = px;
		win_y[0] = win_y[1];
		win_y[1] = win_y[2];
		win_y[2] = py;
		if (points_held < 3) points_held++;
	endtask

	// predict on accepted inputs, track register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) step_pixels = cfg_wdata;
			if (in_valid && in_ready) rasterize_point(point_x, point_y, first_point);
		end
	end

	// check each accepted result
	always @(posedge clk) begin
		curve_point_t cp;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$display("%0t unexpected point x=%0d y=%0d pen=%0d last=%0d",
					$time, out_x, out_y, pen_down, last_of_run);
				errors++;
			end else begin
				cp = pending_points.pop_front();
				if (out_x !== cp.x || out_y !== cp.y || pen_down !== cp.pen ||
						last_of_run !== cp.last) begin
					$display("%0t mismatch expected x=%0d y=%0d pen=%0d last=%0d",
						$time, cp.x, cp.y, cp.pen, cp.last);
					$display("%0t          actual   x=%0d y=%0d pen=%0d last=%0d",
						$time, out_x, out_y, pen_down, last_of_run);
					errors++;
				end
			end
		end
	end

	// receiver: random idling plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (!arst_n) out_ready = 1'b0;
		else if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else out_ready = ($urandom_range(0, 99) >= recv_gap);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t timeout, %0d points outstanding", $time, pending_points.size());
			$display("[cubic_bspline_point_generator] ERROR");
			$finish;
		end
	end

	task automatic send_point(input int x, input int y, input bit first);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap) begin
			in_valid = 1'b0;
			point_x = cbs_pkg::coord_t'($urandom);
			@(negedge clk);
		end
		point_x = cbs_pkg::coord_t'(x);
		point_y = cbs_pkg::coord_t'(y);
		first_point = first;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_step(input int v);
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = 4'(v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic int clip(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// one curve: first point then further points near a random base, or anywhere when reach is zero
	task automatic send_curve(input int npts, input int reach);
		int bx, by;
		bx = $signed(16'($urandom));
		by = $signed(16'($urandom));
		for (int i = 0; i < npts; i++) begin
			if (reach == 0)
				send_point($signed(16'($urandom)), $signed(16'($urandom)), i == 0);
			else
				send_point(clip(bx + $urandom_range(0, 2 * reach) - reach),
					clip(by + $urandom_range(0, 2 * reach) - reach), i == 0);
		end
	endtask

	task automatic test_directed();
		// fewer than three points, restarted once
		send_point(5, 5, 1);
		send_point(-32768, 32767, 1);
		send_point(7, -7, 0);
		// full-range window, clamped count
		send_point(-32768, -32768, 1);
		send_point(32767, 32767, 0);
		send_point(-32768, 0, 0);
		send_point(32767, -32768, 0);
		send_point(0, 32767, 0);
		// zero span
		send_point(100, 100, 1);
		send_point(100, 100, 0);
		send_point(100, 100, 0);
		send_point(100, 100, 0);
		// span below step
		send_point(0, 0, 1);
		send_point(10, 10, 0);
		send_point(12, 11, 0);
		send_point(40, -3, 0);
		// first flag in the middle of a curve
		send_point(-1, -1, 1);
		send_point(30, -20, 0);
		send_point(-20, 30, 1);
		send_point(60, 60, 0);
		send_point(-60, 90, 0);
		send_point(20, -40, 0);
	endtask

	task automatic test_step_settings();
		int steps[3] = '{1, 15, 0};
		foreach (steps[i]) begin
			write_step(steps[i]);
			send_curve(5, 40);
			send_point(3, 3, 1);
			send_point(3, 3, 0);
			send_point(3, 3, 0);
			send_point(-3, 9, 0);
		end
		write_step(15);
		send_curve(4, 0);
	endtask

	task automatic test_random(input int sgap, input int rgap, input int items);
		int sent;
		sent = 0;
		send_gap = sgap;
		recv_gap = rgap;
		write_step($urandom_range(1, 15));
		while (sent < items) begin
			case ($urandom_range(0, 9))
				0: begin
					send_point($signed(16'($urandom)), $signed(16'($urandom)), $urandom_range(0, 1));
					sent++;
				end
				1: begin
					send_curve(4, 0);
					sent += 4;
				end
				default: begin
					send_curve(4 + $urandom_range(0, 4), $urandom_range(2, 40));
					sent += 6;
				end
			endcase
		end
	endtask

	task automatic test_output_stall();
		send_gap = 0;
		recv_gap = 0;
		write_step(4);
		hold_req = 1500;
		send_curve(8, 30);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		first_point = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		out_ready = 1'b0;
		errors = 0;
		hold_req = 0;
		hold_left = 0;
		quiet_cycles = 0;
		send_gap = 32;
		recv_gap = 50;
		step_pixels = cbs_pkg::PPS_RESET;
		points_held = 0;
		for (int i = 0; i < 3; i++) begin
			win_x[i] = 0;
			win_y[i] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_step_settings();
		test_random(32, 50, 35);
		test_random(50, 32, 35);
		test_random(0, 0, 35);
		test_output_stall();

		wait_drained();
		if (errors == 0) $display("[cubic_bspline_point_generator] OK");
		else $display("[cubic_bspline_point_generator] ERROR");
		$finish;
	end

endmodule
